// ===== src/scr_pkg.sv =====
// shared widths and constants for the stick response curve pipeline
package scr_pkg;

  localparam int AXIS_W    = 16;
  localparam int MAG_W     = 15;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int P4_W      = 2 * SQ_W;
  localparam int DEN_W     = P4_W + 1;
  localparam int DIV_STEPS = MAG_W;
  // magnitude, squares, fourth powers, sum, divide steps, output
  localparam int STAGES    = DIV_STEPS + 5;

  localparam logic [MAG_W-1:0] FULL_SCALE = 15'h7FFF;
  localparam logic [MAG_W-1:0] DZ_RESET   = 15'd33;

endpackage

// ===== src/stick_sigmoid_response_curve_top.sv =====
// stick response curve: s-curve on the magnitude, dead zone, sign restore
// pipeline: 20 register stages from input transaction to output valid
// throughput: one transaction per cycle when not stalled; the stages share one
// advance enable set by the output register; stage 0 also fills while that waits
// divider: 15 restoring steps, one quotient bit per stage, one 62-bit compare each
// reset: rst is synchronous, clears all valid bits, dead_zone returns to 33
module stick_sigmoid_response_curve_top
  import scr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [AXIS_W-1:0] axis_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [AXIS_W-1:0] curved_value,
  input  logic                     cfg_wen,
  input  logic        [MAG_W-1:0]  cfg_wdata
);

  // dead zone register: user must write only while pipeline is drained; unchecked
  logic [MAG_W-1:0] dead_zone;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DZ_RESET;
    end else if (cfg_wen) begin
      dead_zone <= cfg_wdata;
    end
  end

  // stage valid bits; the last one is the output register
  logic [STAGES-1:0] vld;
  logic              en;
  logic              ld0;

  // whole pipeline moves when the output register is free or being taken
  assign en        = !vld[STAGES-1] || out_ready;
  // stage 0 may still fill into a hole while the rest is held
  assign ld0       = en || !vld[0];
  assign in_ready  = ld0;
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld0) begin
        vld[0] <= in_valid;
      end
      if (en) begin
        vld[STAGES-1:1] <= vld[STAGES-2:0];
      end
    end
  end

  // stage 0: sign split, magnitude clamp to full scale, complement
  logic [AXIS_W-1:0] raw_neg;
  logic [AXIS_W-1:0] mag_raw;
  logic [MAG_W-1:0]  mag_clamped;
  logic              s0_neg;
  logic [MAG_W-1:0]  s0_a;
  logic [MAG_W-1:0]  s0_c;

  assign raw_neg     = AXIS_W'(~axis_value + 16'd1);
  assign mag_raw     = axis_value[AXIS_W-1] ? raw_neg : axis_value;
  // only the most negative sample has the top bit left after negation
  assign mag_clamped = mag_raw[AXIS_W-1] ? FULL_SCALE : mag_raw[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (ld0) begin
      s0_neg <= axis_value[AXIS_W-1];
      s0_a   <= mag_clamped;
      s0_c   <= FULL_SCALE - mag_clamped;
    end
  end

  // stage 1: squares
  logic             s1_neg;
  logic [SQ_W-1:0]  s1_a2;
  logic [SQ_W-1:0]  s1_c2;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg <= s0_neg;
      s1_a2  <= SQ_W'(s0_a) * SQ_W'(s0_a);
      s1_c2  <= SQ_W'(s0_c) * SQ_W'(s0_c);
    end
  end

  // stage 2: fourth powers
  logic             s2_neg;
  logic [P4_W-1:0]  s2_a4;
  logic [P4_W-1:0]  s2_c4;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg <= s1_neg;
      s2_a4  <= P4_W'(s1_a2) * P4_W'(s1_a2);
      s2_c4  <= P4_W'(s1_c2) * P4_W'(s1_c2);
    end
  end

  // stage 3 fills entry 0 of the divider chain: numerator, denominator
  logic [DEN_W-1:0] div_r   [DIV_STEPS+1];
  logic [MAG_W-1:0] div_q   [DIV_STEPS+1];
  logic [P4_W-1:0]  div_n   [DIV_STEPS+1];
  logic [DEN_W-1:0] div_d   [DIV_STEPS+1];
  logic             div_neg [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0]   <= DEN_W'(s2_a4);
      div_q[0]   <= '0;
      div_n[0]   <= s2_a4;
      div_d[0]   <= DEN_W'(s2_a4) + DEN_W'(s2_c4);
      div_neg[0] <= s2_neg;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {div_r[k], 1'b0};
    assign diff  = trial - {1'b0, div_d[k]};
    assign take  = trial >= {1'b0, div_d[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k+1]   <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        div_q[k+1]   <= {div_q[k][MAG_W-2:0], take};
        div_n[k+1]   <= div_n[k];
        div_d[k+1]   <= div_d[k];
        div_neg[k+1] <= div_neg[k];
      end
    end
  end

  // output stage: turn 2^15 scaling into 32767 scaling, dead zone, sign
  logic              fix_down;
  logic [MAG_W-1:0]  y_curved;
  logic [MAG_W-1:0]  y_mag;
  logic [AXIS_W-1:0] y_pos;
  logic [AXIS_W-1:0] y_out;

  // n * 2^15 = q * d + r, and 32767 * n is n less, so one down when r < n
  assign fix_down = div_r[DIV_STEPS] < DEN_W'(div_n[DIV_STEPS]);
  assign y_curved = fix_down ? div_q[DIV_STEPS] - 15'd1 : div_q[DIV_STEPS];
  assign y_mag    = (y_curved < dead_zone) ? '0 : y_curved;
  assign y_pos    = {1'b0, y_mag};
  assign y_out    = div_neg[DIV_STEPS] ? AXIS_W'(16'd0 - y_pos) : y_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      curved_value <= $signed(y_out);
    end
  end

  // an empty output register never holds back the input
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // divider remainder never exceeds the denominator; full deflection keeps it equal
  assert property (@(posedge clk) disable iff (rst)
    vld[STAGES-2] |-> (div_r[DIV_STEPS] <= div_d[DIV_STEPS]))
    else $error("divider remainder out of range");

  // curve output never reaches the most negative code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (curved_value != 16'sh8000))
    else $error("curved value out of range");

  // a positive nonzero result is never inside the dead zone
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !curved_value[AXIS_W-1] && (curved_value != 16'sd0))
      |-> (curved_value[MAG_W-1:0] >= dead_zone))
    else $error("result inside dead zone");

endmodule

// ===== verif/curve_checker.sv =====
// checker for the stick response curve: predicts each curved value and compares it at the output
module curve_checker
  import scr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [AXIS_W-1:0] axis_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [AXIS_W-1:0] curved_value,
  input  logic                     cfg_wen,
  input  logic        [MAG_W-1:0]  cfg_wdata,
  output int                       mismatch_count,
  output int                       outstanding,
  output int                       checked_count
);

  localparam logic [MAG_W-1:0] ZONE_AT_RESET = 15'd33;
  localparam int               REPORT_LIMIT  = 10;

  typedef struct {
    logic signed [AXIS_W-1:0] sample;
    logic        [MAG_W-1:0]  zone;
    logic signed [AXIS_W-1:0] curved;
  } curve_expect_t;

  curve_expect_t    expected_curves[$];
  logic [MAG_W-1:0] zone;
  int               failures = 0;
  int               checked = 0;

  // s-curve a^4 / (a^4 + c^4) on the clamped magnitude, dead zone, then sign back
  function automatic logic signed [AXIS_W-1:0] curve_axis(
      input logic signed [AXIS_W-1:0] sample, input logic [MAG_W-1:0] dz);
    logic [AXIS_W:0]  mag;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] c;
    logic [127:0]     a4;
    logic [127:0]     c4;
    logic [127:0]     quo;
    logic [MAG_W-1:0] y;
    logic [AXIS_W-1:0] curve;
    mag = sample[AXIS_W-1] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
    a = (mag > 17'd32767) ? 15'h7FFF : mag[MAG_W-1:0];
    c = 15'h7FFF - a;
    a4 = 128'(a);
    a4 = a4 * a4;
    a4 = a4 * a4;
    c4 = 128'(c);
    c4 = c4 * c4;
    c4 = c4 * c4;
    quo = (a4 * 128'd32767) / (a4 + c4);
    y = quo[MAG_W-1:0];
    if (y < dz) y = '0;
    curve = {1'b0, y};
    if (sample[AXIS_W-1]) curve = -curve;
    return $signed(curve);
  endfunction

  always @(posedge clk) begin : watch
    curve_expect_t head;
    curve_expect_t fresh;
    if (rst) begin
      zone = ZONE_AT_RESET;
      expected_curves.delete();
    end else begin
      if (in_valid && in_ready) begin
        fresh.sample = axis_value;
        fresh.zone   = zone;
        fresh.curved = curve_axis(axis_value, zone);
        expected_curves.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        if (expected_curves.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("curve checker: unexpected result %0d", curved_value);
          failures++;
        end else begin
          head = expected_curves.pop_front();
          checked++;
          if (curved_value !== head.curved) begin
            if (failures < REPORT_LIMIT)
              $display("curve checker: sample %0d zone %0d expected %0d got %0d",
                       head.sample, head.zone, head.curved, curved_value);
            failures++;
          end
        end
      end
      if (cfg_wen) zone = cfg_wdata;
    end
    mismatch_count <= failures;
    outstanding    <= expected_curves.size();
    checked_count  <= checked;
  end

endmodule

// ===== verif/testbench.sv =====
// stimulus, flow control and verdict for the stick response curve block
module testbench;
  import scr_pkg::*;

  // pipeline depth of the block, per its header
  localparam int PIPE_LATENCY  = 20;
  localparam int PHASE_SAMPLES = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ZONE_SETTINGS = 6;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [AXIS_W-1:0] axis_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [AXIS_W-1:0] curved_value;
  logic                     cfg_wen = 1'b0;
  logic        [MAG_W-1:0]  cfg_wdata = '0;

  // asks the receiver for its one long hold-off
  logic start_hold = 1'b0;

  int mismatch_count;
  int outstanding;
  int checked_count;
  int samples_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stick_sigmoid_response_curve_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .axis_value   (axis_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .curved_value (curved_value),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata)
  );

  curve_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .axis_value     (axis_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .curved_value   (curved_value),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count)
  );

  // present one sample and hold it until the transaction completes;
  // valid stays high on return so back-to-back calls keep it up
  task automatic offer_sample(input logic [AXIS_W-1:0] v);
    in_valid   <= 1'b1;
    axis_value <= $signed(v);
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // random sample weighted toward the interesting parts of the curve
  function automatic logic [AXIS_W-1:0] pick_sample();
    logic [AXIS_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = 16'($urandom_range(0, 65535));     // any bit pattern
      3, 4:    v = 16'($urandom_range(0, 8191));      // near zero, dead zone territory
      5, 6:    v = 16'($urandom_range(24000, 32767)); // near full deflection
      7:       v = 16'($urandom_range(4000, 8000));   // around the default threshold
      8: begin
        case ($urandom_range(0, 5))
          0:       v = 16'h0000;
          1:       v = 16'h7FFF;
          2:       v = 16'h8000;
          3:       v = 16'h0001;
          4:       v = 16'h4000;
          default: v = 16'h3FFF;
        endcase
      end
      default: v = 16'($urandom_range(0, 32767));
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // bursts of random length, random gaps, and some gapless stretches
  task automatic send_random_samples(input int count);
    int sent = 0;
    int burst;
    int gap;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < count; k++) begin
        offer_sample(pick_sample());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending, wait for every expected result, then let the pipe settle
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_dead_zone(input logic [MAG_W-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // stimulus: directed corners under the reset dead zone, then random phases
  initial begin : stimulus
    logic [AXIS_W-1:0] corners[$];
    logic [MAG_W-1:0]  zones[ZONE_SETTINGS];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero, unit steps, both full scales, the most negative sample,
    // half scale, and samples between 5700 and 5900
    corners = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8001, 16'h8000,
                16'h4000, 16'hC000, 16'h3FFF, 16'h0064, 16'hFF9C, 16'd5700,
                16'd5800, 16'd5830, 16'd5860, 16'd5900, -16'd5830, 16'h5555,
                16'hAAAA, 16'h7FFE, 16'h0FFF, 16'hF001};
    foreach (corners[i]) offer_sample(corners[i]);
    drain_pipeline();

    // zero, full scale, one, half, anything, and a modest random value
    zones = '{15'd0, 15'h7FFF, 15'd1, 15'h4000,
              15'($urandom_range(0, 32767)), 15'($urandom_range(0, 2000))};
    for (int p = 0; p < ZONE_SETTINGS; p++) begin
      write_dead_zone(zones[p]);
      // long output stall while the sender keeps pushing
      if (p == 1) start_hold <= 1'b1;
      send_random_samples(PHASE_SAMPLES);
      drain_pipeline();
    end

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    $display("covered %0d axis samples, %0d results checked, over %0d dead-zone settings",
             samples_sent, checked_count, ZONE_SETTINGS + 1);
    $display("settings included reset, 0, 1, 16384, 32767 and random; one %0d-cycle stall",
             HOLD_CYCLES);
    if (mismatch_count == 0 && outstanding == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  // receiver: stretches of always-ready, coin-flip, rare stall and periodic stall
  initial begin : receiver
    int span;
    int mode;
    int tick = 0;
    bit held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (start_hold && !held) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= ((tick % 16) < 10);
          endcase
        end
      end
    end
  end

  // timeout guard
  initial begin : watchdog
    int cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/scr_pkg.sv
src/stick_sigmoid_response_curve_top.sv
verif/curve_checker.sv
verif/testbench.sv
